FILE: hdl/pmce_pkg.sv
// pmce_pkg: shared constants, payload structs and controller/datapath signal groups
// for the plotter move command encoder. No dependencies.

package pmce_pkg;

  localparam int COORD_BITS = 24;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int PROD_BITS  = COORD_BITS + 4;

  localparam int DELTA_MAX = 8191;
  localparam int DELTA_MIN = -8192;

  localparam logic [63:0] POW10_TABLE [10] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000,
    64'd1000000, 64'd10000000, 64'd100000000, 64'd1000000000
  };

  // digits needed for the largest magnitude, 2^(bits-1)
  function automatic int num_digits(int bits);
    int n;
    n = 1;
    for (int i = 1; i < 10; i++) begin
      if (POW10_TABLE[i] <= (64'd1 << (bits - 1))) n = i + 1;
    end
    return n;
  endfunction

  localparam int NUM_DIGITS = num_digits(COORD_BITS);
  localparam int POS_BITS   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  localparam logic [7:0] CH_DRAW_REL = 8'h53;  // 'S'
  localparam logic [7:0] CH_MOVE_REL = 8'h54;  // 'T'
  localparam logic [7:0] CH_DRAW_ABS = 8'h44;  // 'D'
  localparam logic [7:0] CH_MOVE_ABS = 8'h55;  // 'U'
  localparam logic [7:0] CH_MINUS    = 8'h2d;
  localparam logic [7:0] CH_COMMA    = 8'h2c;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_ZERO     = 8'h30;

  typedef struct packed {
    logic signed [23:0] x_steps;
    logic signed [23:0] y_steps;
    logic               pen_down;
  } point_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } cmd_byte_t;

  typedef enum logic [3:0] {
    BK_CMD,
    BK_DX_HI,
    BK_DX_LO,
    BK_DY_HI,
    BK_DY_LO,
    BK_MINUS,
    BK_DIGIT,
    BK_COMMA,
    BK_CR
  } byte_kind_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    byte_kind_t kind;
    logic       mag_load;
    logic       mag_sel_y;
    logic       digit_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic short_fit;
    logic x_neg;
    logic y_neg;
    logic digit_zero;
    logic started;
    logic pos_zero;
  } ctrl_sts_t;

endpackage

FILE: hdl/pmce_datapath.sv
// pmce_datapath: previous point, deltas, decimal digit unit, byte select and the
// output register. Depends on pmce_pkg; driven by pmce_ctrl commands.

module pmce_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pmce_pkg::point_t    point,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  input  pmce_pkg::ctrl_cmd_t cmd,
  output pmce_pkg::ctrl_sts_t sts,
  output logic                byte_valid,
  input  logic                byte_stall,
  output pmce_pkg::cmd_byte_t cmd_byte
);

  localparam int C = pmce_pkg::COORD_BITS;
  localparam int W = pmce_pkg::DELTA_BITS;
  localparam int P = pmce_pkg::PROD_BITS;
  localparam logic [pmce_pkg::POS_BITS-1:0] POS_TOP =
    pmce_pkg::POS_BITS'(pmce_pkg::NUM_DIGITS - 1);
  localparam logic signed [W-1:0] LIM_HI = W'(pmce_pkg::DELTA_MAX);
  localparam logic signed [W-1:0] LIM_LO = W'(pmce_pkg::DELTA_MIN);

  logic                           dry_run;
  logic signed [C-1:0]            prev_x;
  logic signed [C-1:0]            prev_y;
  logic signed [W-1:0]            dx;
  logic signed [W-1:0]            dy;
  logic                           draw;
  logic [C-1:0]                   mag;
  logic [pmce_pkg::POS_BITS-1:0]  pos;
  logic                           started;

  logic signed [C-1:0]            new_x;
  logic signed [C-1:0]            new_y;
  logic [C-1:0]                   abs_x;
  logic [C-1:0]                   abs_y;
  logic [P-1:0]                   pow;
  logic [P-1:0]                   prod;
  logic [P-1:0]                   sub;
  logic [3:0]                     digit;
  logic                           short_fit;
  logic [7:0]                     byte_sel;

  assign new_x = C'(point.x_steps);
  assign new_y = C'(point.y_steps);
  assign abs_x = prev_x[C-1] ? (~prev_x + 1'b1) : prev_x;
  assign abs_y = prev_y[C-1] ? (~prev_y + 1'b1) : prev_y;
  assign short_fit = (dx <= LIM_HI) && (dx >= LIM_LO) && (dy <= LIM_HI) && (dy >= LIM_LO);

  // one decimal digit per step, by compare against the nine multiples
  always_comb begin
    pow   = pmce_pkg::POW10_TABLE[4'(pos)][P-1:0];
    digit = 4'd0;
    sub   = '0;
    prod  = '0;
    for (int d = 1; d < 10; d++) begin
      prod = P'(pow * 4'(d));
      if ({4'b0, mag} >= prod) begin
        digit = 4'(d);
        sub   = prod;
      end
    end
  end

  always_comb begin
    case (cmd.kind)
      pmce_pkg::BK_CMD: begin
        if (short_fit) byte_sel = draw ? pmce_pkg::CH_DRAW_REL : pmce_pkg::CH_MOVE_REL;
        else byte_sel = draw ? pmce_pkg::CH_DRAW_ABS : pmce_pkg::CH_MOVE_ABS;
      end
      pmce_pkg::BK_DX_HI: byte_sel = {1'b1, dx[13:7]};
      pmce_pkg::BK_DX_LO: byte_sel = {1'b1, dx[6:0]};
      pmce_pkg::BK_DY_HI: byte_sel = {1'b1, dy[13:7]};
      pmce_pkg::BK_DY_LO: byte_sel = {1'b1, dy[6:0]};
      pmce_pkg::BK_MINUS: byte_sel = pmce_pkg::CH_MINUS;
      pmce_pkg::BK_DIGIT: byte_sel = pmce_pkg::CH_ZERO + {4'b0, digit};
      pmce_pkg::BK_COMMA: byte_sel = pmce_pkg::CH_COMMA;
      pmce_pkg::BK_CR:    byte_sel = pmce_pkg::CH_CR;
      default:            byte_sel = pmce_pkg::CH_CR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_run <= 1'b0;
      prev_x  <= '0;
      prev_y  <= '0;
    end else begin
      if (cfg_valid) dry_run <= cfg_data;
      if (cmd.load) begin
        prev_x <= new_x;
        prev_y <= new_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx   <= {new_x[C-1], new_x} - {prev_x[C-1], prev_x};
      dy   <= {new_y[C-1], new_y} - {prev_y[C-1], prev_y};
      draw <= point.pen_down && !dry_run;
    end
    if (cmd.mag_load) begin
      mag     <= cmd.mag_sel_y ? abs_y : abs_x;
      pos     <= POS_TOP;
      started <= 1'b0;
    end else if (cmd.digit_step) begin
      mag     <= mag - sub[C-1:0];
      pos     <= pos - 1'b1;
      started <= started || (digit != 4'd0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (cmd.emit) begin
      byte_valid <= 1'b1;
    end else if (!byte_stall) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cmd_byte.out_byte  <= byte_sel;
      cmd_byte.last_byte <= (cmd.kind == pmce_pkg::BK_CR);
    end
  end

  assign sts.out_free   = !byte_valid || !byte_stall;
  assign sts.short_fit  = short_fit;
  assign sts.x_neg      = prev_x[C-1];
  assign sts.y_neg      = prev_y[C-1];
  assign sts.digit_zero = (digit == 4'd0);
  assign sts.started    = started;
  assign sts.pos_zero   = (pos == '0);

endmodule

FILE: hdl/pmce_ctrl.sv
// pmce_ctrl: command sequencer for one point, relative or absolute form.
// Depends on pmce_pkg; drives pmce_datapath through ctrl_cmd_t.

module pmce_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                point_valid,
  output logic                point_stall,
  input  pmce_pkg::ctrl_sts_t sts,
  output pmce_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_DX_HI,
    ST_DX_LO,
    ST_DY_HI,
    ST_DY_LO,
    ST_X_SIGN,
    ST_X_DIG,
    ST_COMMA,
    ST_Y_SIGN,
    ST_Y_DIG,
    ST_CR
  } state_t;

  state_t state;
  state_t state_next;
  logic   skip;

  assign point_stall = (state != ST_IDLE);
  // leading zero, not the units digit
  assign skip = sts.digit_zero && !sts.started && !sts.pos_zero;

  always_comb begin
    cmd        = '0;
    cmd.kind   = pmce_pkg::BK_CR;
    state_next = state;
    unique case (state) inside
      ST_IDLE: begin
        if (point_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CMD;
        end
      end
      ST_CMD: begin
        cmd.kind = pmce_pkg::BK_CMD;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.short_fit ? ST_DX_HI : ST_X_SIGN;
        end
      end
      ST_DX_HI: begin
        cmd.kind = pmce_pkg::BK_DX_HI;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_DX_LO;
        end
      end
      ST_DX_LO: begin
        cmd.kind = pmce_pkg::BK_DX_LO;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_DY_HI;
        end
      end
      ST_DY_HI: begin
        cmd.kind = pmce_pkg::BK_DY_HI;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_DY_LO;
        end
      end
      ST_DY_LO: begin
        cmd.kind = pmce_pkg::BK_DY_LO;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_CR;
        end
      end
      ST_X_SIGN, ST_Y_SIGN: begin
        cmd.kind      = pmce_pkg::BK_MINUS;
        cmd.mag_sel_y = (state == ST_Y_SIGN);
        if (sts.out_free) begin
          cmd.emit     = (state == ST_Y_SIGN) ? sts.y_neg : sts.x_neg;
          cmd.mag_load = 1'b1;
          state_next   = (state == ST_Y_SIGN) ? ST_Y_DIG : ST_X_DIG;
        end
      end
      ST_X_DIG, ST_Y_DIG: begin
        cmd.kind = pmce_pkg::BK_DIGIT;
        if (skip) begin
          cmd.digit_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.digit_step = 1'b1;
          if (sts.pos_zero) state_next = (state == ST_Y_DIG) ? ST_CR : ST_COMMA;
        end
      end
      ST_COMMA: begin
        cmd.kind = pmce_pkg::BK_COMMA;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_Y_SIGN;
        end
      end
      ST_CR: begin
        cmd.kind = pmce_pkg::BK_CR;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_CMD)
    else $error("point load did not start a command");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("byte emitted into a full output register");

  a_cr_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.kind == pmce_pkg::BK_CR |=> state == ST_IDLE)
    else $error("command did not end after carriage return");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !cmd.emit && !cmd.digit_step && !cmd.mag_load)
    else $error("datapath activity while idle");

endmodule

FILE: hdl/plotter_move_command_encoder_core.sv
// plotter_move_command_encoder_core: top level, sequencer plus datapath.
// Depends on pmce_pkg, pmce_ctrl and pmce_datapath.
//
// Usage:
//   point channel (point_valid / point_stall / point): one target point per
//   request. A request is taken when point_valid is high and point_stall low.
//   byte channel (byte_valid / byte_stall / cmd_byte): the command bytes of
//   that point, one per request, last_byte set on the closing carriage return.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): dry-run flag, always ready;
//   write it only while no command is in progress.
// Timing:
//   the point is loaded in the idle state and the first byte is emitted from
//   the command state into the output register; then one byte per cycle
//   while the receiver does not stall, except that a sign slot of a positive
//   coordinate and a skipped leading zero give no byte. An absolute command
//   has a sign slot and seven digit positions per coordinate. The sequencer
//   holds point_stall high until the carriage return is registered, so the
//   next point is taken only after the command of the last one is complete.
// Stall: a stalled byte holds in the output register and the sequencer waits.
// Reset: previous point is cleared to zero, dry-run off, no byte pending.

module plotter_move_command_encoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                point_valid,
  output logic                point_stall,
  input  pmce_pkg::point_t    point,
  output logic                byte_valid,
  input  logic                byte_stall,
  output pmce_pkg::cmd_byte_t cmd_byte,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  pmce_pkg::ctrl_cmd_t cmd;
  pmce_pkg::ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  pmce_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  pmce_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .point      (point),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .cmd_byte   (cmd_byte)
  );

endmodule
